// File: rtl/rsc_pkg.sv
// Shared types, constants and fixed-point helpers for the spherical-to-Cartesian
// converter with converted-measurement covariance. No dependencies.
package rsc_pkg;

   typedef logic signed [33:0] f_type;
   typedef logic signed [31:0] q30_type;
   typedef logic signed [24:0] pos_type;
   typedef logic signed [63:0] cov_type;

   localparam int MATH_STAGES = 8;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [1:0] CSR_AZIMUTH_SIGMA = 2'd0;
   localparam logic [1:0] CSR_ZENITH_SIGMA  = 2'd1;
   localparam logic [1:0] CSR_RANGE_SIGMA   = 2'd2;

   localparam f_type CORDIC_GAIN = 34'sd652032874;
   localparam f_type Q30_ONE     = 34'sd1073741824;
   localparam f_type POS_MAX     = 34'sd16777215;

   localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Rounded Q30 product: floor((a*b + 2^29) / 2^30).
   function automatic f_type rnd30(input f_type a, input f_type b);
      logic signed [67:0] p;
      p = a * b + 68'sd536870912;
      return p[63:30];
   endfunction

   function automatic q30_type sat_q30(input f_type v);
      if (v > Q30_ONE) begin
         return 32'sd1073741824;
      end else if (v < -Q30_ONE) begin
         return -32'sd1073741824;
      end
      return v[31:0];
   endfunction

   function automatic pos_type sat_pos(input f_type v);
      if (v > POS_MAX) begin
         return 25'sd16777215;
      end else if (v < -POS_MAX) begin
         return -25'sd16777215;
      end
      return v[24:0];
   endfunction

   function automatic cov_type sat_cov(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (v < -66'sh0_8000_0000_0000_0000) begin
         return 64'sh8000_0000_0000_0000;
      end
      return v[63:0];
   endfunction

endpackage

// File: rtl/rsc_pipe_ctrl.sv
// Valid tracking and per-stage load enables for the converter pipeline.
// Depends on nothing; bubbles are squeezed out so a stalled output never blocks free stages.
module rsc_pipe_ctrl #(
   parameter int DEPTH = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DEPTH-1:0] stage_en
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] hole;

   always_comb begin
      hole = ~valid_ff;
      for (int k = 0; k < DEPTH; k++) begin
         stage_en[k] = out_ready | (|(hole >> k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < DEPTH; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[DEPTH-1];

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("Accepted beat did not enter the first stage.");

   a_ready_frees_all: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> stage_en == {DEPTH{1'b1}})
      else $error("Pipeline stalled although the output was taken.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid)
      else $error("Stalled result beat was dropped.");

endmodule

// File: rtl/rsc_cordic.sv
// Pipelined rotation-mode CORDIC giving Q30 sine and cosine of a 16-bit binary angle.
// Depends on rsc_pkg for the gain, arctangent table and clamp helper.
module rsc_cordic #(
   parameter int STAGES = 16
) (
   input  logic                clock,
   input  logic [STAGES+1:0]   stage_en,
   input  logic [15:0]         angle,
   output logic signed [31:0]  sin_out,
   output logic signed [31:0]  cos_out
);
   import rsc_pkg::*;

   f_type   x_ff    [0:STAGES];
   f_type   y_ff    [0:STAGES];
   f_type   z_ff    [0:STAGES];
   logic    flip_ff [0:STAGES];
   q30_type sin_ff;
   q30_type cos_ff;
   logic [31:0] z_start;

   // Angles in the second and third quadrant are rotated by half a turn.
   assign z_start = {angle[14], angle[14:0], 16'h0000};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= 34'($signed(z_start));
         flip_ff[0] <= angle[15] ^ angle[14];
      end
   end

   for (genvar i = 1; i <= STAGES; i++) begin : g_iter
      localparam f_type ATAN_K = $signed({2'b00, ATAN_TURNS[i-1]});
      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            if (!z_ff[i-1][33]) begin
               x_ff[i] <= x_ff[i-1] - (y_ff[i-1] >>> (i - 1));
               y_ff[i] <= y_ff[i-1] + (x_ff[i-1] >>> (i - 1));
               z_ff[i] <= z_ff[i-1] - ATAN_K;
            end else begin
               x_ff[i] <= x_ff[i-1] + (y_ff[i-1] >>> (i - 1));
               y_ff[i] <= y_ff[i-1] - (x_ff[i-1] >>> (i - 1));
               z_ff[i] <= z_ff[i-1] + ATAN_K;
            end
            flip_ff[i] <= flip_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGES+1]) begin
         cos_ff <= sat_q30(flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES]);
         sin_ff <= sat_q30(flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES]);
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// File: rtl/rsc_cov.sv
// Position and covariance arithmetic: trig products, covariance factors and split
// exact rounding of the six terms over eight register stages. Depends on rsc_pkg.
module rsc_cov (
   input  logic                                  clock,
   input  logic [rsc_pkg::MATH_STAGES-1:0]       stage_en,
   input  logic [23:0]                           slant_range,
   input  logic signed [31:0]                    sin_az,
   input  logic signed [31:0]                    cos_az,
   input  logic signed [31:0]                    sin_ze,
   input  logic signed [31:0]                    cos_ze,
   input  logic [15:0]                           azimuth_sigma,
   input  logic [15:0]                           zenith_sigma,
   input  logic [15:0]                           range_sigma,
   output rsc_pkg::pos_type                      pos_x,
   output rsc_pkg::pos_type                      pos_y,
   output rsc_pkg::pos_type                      pos_z,
   output rsc_pkg::cov_type                      cov_xx,
   output rsc_pkg::cov_type                      cov_xy,
   output rsc_pkg::cov_type                      cov_xz,
   output rsc_pkg::cov_type                      cov_yy,
   output rsc_pkg::cov_type                      cov_yz,
   output rsc_pkg::cov_type                      cov_zz
);
   import rsc_pkg::*;

   f_type r_w, sa_w, ca_w, sz_w, cz_w, a_w, z_w;
   logic [32:0] asq_w, zsq_w;

   f_type rs_1_ff, sa_1_ff, ca_1_ff, sa2_1_ff, ca2_1_ff, sz2_1_ff, cz2_1_ff;
   f_type saca_1_ff, szcz_1_ff, a_1_ff, z_1_ff;
   pos_type posz_1_ff;
   logic [47:0] r2_1_ff;
   logic [31:0] s_1_ff;

   pos_type posx_2_ff, posy_2_ff, posz_2_ff;
   f_type sa2cz2_2_ff, sa2sz2_2_ff, ca2cz2_2_ff, ca2sz2_2_ff, szcza_2_ff, szczsa_2_ff;
   f_type az_2_ff, cz2_2_ff, sz2_2_ff, saca_2_ff, a_2_ff, z_2_ff;
   logic [48:0] m_2_ff;
   logic [31:0] s_2_ff;

   pos_type posx_3_ff, posy_3_ff, posz_3_ff;
   f_type t11a_3_ff, t11b_3_ff, t11c_3_ff, t22a_3_ff, t22b_3_ff, t22c_3_ff;
   f_type i1_3_ff, i2_3_ff, i3_3_ff, g12_3_ff, f13_3_ff, f23_3_ff, f33_3_ff;
   f_type g11_3_ff, g22_3_ff, g13_3_ff, g23_3_ff, g33_3_ff, saca_3_ff;
   logic [48:0] m_3_ff;
   logic [31:0] s_3_ff;

   pos_type posx_4_ff, posy_4_ff, posz_4_ff;
   f_type f11_4_ff, f22_4_ff, inner_4_ff, g12_4_ff, f13_4_ff, f23_4_ff, f33_4_ff;
   f_type g11_4_ff, g22_4_ff, g13_4_ff, g23_4_ff, g33_4_ff, saca_4_ff;
   logic [48:0] m_4_ff;
   logic [31:0] s_4_ff;

   pos_type posx_5_ff, posy_5_ff, posz_5_ff;
   f_type f_5_ff [0:5];
   f_type g_5_ff [0:5];
   logic [48:0] m_5_ff;
   logic [31:0] s_5_ff;

   logic signed [19:0] mh_w;
   logic signed [30:0] ml_w;
   logic signed [2:0]  sh_w;
   logic signed [30:0] sl_w;

   pos_type posx_6_ff, posy_6_ff, posz_6_ff;
   logic signed [53:0] phi_6_ff [0:5];
   logic signed [64:0] plo_6_ff [0:5];
   logic signed [36:0] qhi_6_ff [0:5];
   logic signed [64:0] qlo_6_ff [0:5];

   logic signed [65:0] lo_sum_w [0:5];
   pos_type posx_7_ff, posy_7_ff, posz_7_ff;
   logic signed [54:0] hi_7_ff [0:5];
   logic signed [35:0] lo_7_ff [0:5];

   pos_type posx_8_ff, posy_8_ff, posz_8_ff;
   cov_type cov_8_ff [0:5];

   always_comb begin
      r_w   = $signed({10'b0, slant_range});
      sa_w  = 34'(sin_az);
      ca_w  = 34'(cos_az);
      sz_w  = 34'(sin_ze);
      cz_w  = 34'(cos_ze);
      asq_w = 33'(azimuth_sigma) * 33'(azimuth_sigma) + 33'd2;
      zsq_w = 33'(zenith_sigma) * 33'(zenith_sigma) + 33'd2;
      a_w   = $signed({3'b000, asq_w[32:2]});
      z_w   = $signed({3'b000, zsq_w[32:2]});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rs_1_ff   <= rnd30(r_w, sz_w);
         posz_1_ff <= sat_pos(rnd30(r_w, cz_w));
         sa_1_ff   <= sa_w;
         ca_1_ff   <= ca_w;
         sa2_1_ff  <= rnd30(sa_w, sa_w);
         ca2_1_ff  <= rnd30(ca_w, ca_w);
         sz2_1_ff  <= rnd30(sz_w, sz_w);
         cz2_1_ff  <= rnd30(cz_w, cz_w);
         saca_1_ff <= rnd30(sa_w, ca_w);
         szcz_1_ff <= rnd30(sz_w, cz_w);
         a_1_ff    <= a_w;
         z_1_ff    <= z_w;
         r2_1_ff   <= 48'(slant_range) * 48'(slant_range);
         s_1_ff    <= 32'(range_sigma) * 32'(range_sigma);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         posx_2_ff   <= sat_pos(rnd30(rs_1_ff, ca_1_ff));
         posy_2_ff   <= sat_pos(rnd30(rs_1_ff, sa_1_ff));
         posz_2_ff   <= posz_1_ff;
         sa2cz2_2_ff <= rnd30(sa2_1_ff, cz2_1_ff);
         sa2sz2_2_ff <= rnd30(sa2_1_ff, sz2_1_ff);
         ca2cz2_2_ff <= rnd30(ca2_1_ff, cz2_1_ff);
         ca2sz2_2_ff <= rnd30(ca2_1_ff, sz2_1_ff);
         szcza_2_ff  <= rnd30(szcz_1_ff, ca_1_ff);
         szczsa_2_ff <= rnd30(szcz_1_ff, sa_1_ff);
         az_2_ff     <= rnd30(a_1_ff, z_1_ff);
         m_2_ff      <= 49'(r2_1_ff) + 49'(s_1_ff);
         s_2_ff      <= s_1_ff;
         cz2_2_ff    <= cz2_1_ff;
         sz2_2_ff    <= sz2_1_ff;
         saca_2_ff   <= saca_1_ff;
         a_2_ff      <= a_1_ff;
         z_2_ff      <= z_1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         posx_3_ff <= posx_2_ff;
         posy_3_ff <= posy_2_ff;
         posz_3_ff <= posz_2_ff;
         t11a_3_ff <= rnd30(az_2_ff, sa2cz2_2_ff);
         t11b_3_ff <= rnd30(a_2_ff, sa2sz2_2_ff);
         t11c_3_ff <= rnd30(z_2_ff, ca2cz2_2_ff);
         t22a_3_ff <= rnd30(az_2_ff, ca2cz2_2_ff);
         t22b_3_ff <= rnd30(a_2_ff, ca2sz2_2_ff);
         t22c_3_ff <= rnd30(z_2_ff, sa2cz2_2_ff);
         i1_3_ff   <= rnd30(z_2_ff, cz2_2_ff);
         i2_3_ff   <= rnd30(az_2_ff, cz2_2_ff);
         i3_3_ff   <= rnd30(a_2_ff, sz2_2_ff);
         g12_3_ff  <= rnd30(saca_2_ff, sz2_2_ff);
         f13_3_ff  <= -rnd30(z_2_ff, szcza_2_ff);
         f23_3_ff  <= -rnd30(z_2_ff, szczsa_2_ff);
         f33_3_ff  <= rnd30(z_2_ff, sz2_2_ff);
         g11_3_ff  <= ca2sz2_2_ff;
         g22_3_ff  <= sa2sz2_2_ff;
         g13_3_ff  <= szcza_2_ff;
         g23_3_ff  <= szczsa_2_ff;
         g33_3_ff  <= cz2_2_ff;
         saca_3_ff <= saca_2_ff;
         m_3_ff    <= m_2_ff;
         s_3_ff    <= s_2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         posx_4_ff  <= posx_3_ff;
         posy_4_ff  <= posy_3_ff;
         posz_4_ff  <= posz_3_ff;
         f11_4_ff   <= t11a_3_ff + t11b_3_ff + t11c_3_ff;
         f22_4_ff   <= t22a_3_ff + t22b_3_ff + t22c_3_ff;
         inner_4_ff <= i1_3_ff - i2_3_ff - i3_3_ff;
         g12_4_ff   <= g12_3_ff;
         f13_4_ff   <= f13_3_ff;
         f23_4_ff   <= f23_3_ff;
         f33_4_ff   <= f33_3_ff;
         g11_4_ff   <= g11_3_ff;
         g22_4_ff   <= g22_3_ff;
         g13_4_ff   <= g13_3_ff;
         g23_4_ff   <= g23_3_ff;
         g33_4_ff   <= g33_3_ff;
         saca_4_ff  <= saca_3_ff;
         m_4_ff     <= m_3_ff;
         s_4_ff     <= s_3_ff;
      end
   end

   // Term order in the arrays: xx, xy, xz, yy, yz, zz.
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         posx_5_ff  <= posx_4_ff;
         posy_5_ff  <= posy_4_ff;
         posz_5_ff  <= posz_4_ff;
         f_5_ff[0]  <= f11_4_ff;
         f_5_ff[1]  <= rnd30(saca_4_ff, inner_4_ff);
         f_5_ff[2]  <= f13_4_ff;
         f_5_ff[3]  <= f22_4_ff;
         f_5_ff[4]  <= f23_4_ff;
         f_5_ff[5]  <= f33_4_ff;
         g_5_ff[0]  <= g11_4_ff;
         g_5_ff[1]  <= g12_4_ff;
         g_5_ff[2]  <= g13_4_ff;
         g_5_ff[3]  <= g22_4_ff;
         g_5_ff[4]  <= g23_4_ff;
         g_5_ff[5]  <= g33_4_ff;
         m_5_ff     <= m_4_ff;
         s_5_ff     <= s_4_ff;
      end
   end

   // The sum m and the square s are both split at bit 30, so each low part is 30 bits wide.
   always_comb begin
      mh_w = $signed({1'b0, m_5_ff[48:30]});
      ml_w = $signed({1'b0, m_5_ff[29:0]});
      sh_w = $signed({1'b0, s_5_ff[31:30]});
      sl_w = $signed({1'b0, s_5_ff[29:0]});
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         posx_6_ff <= posx_5_ff;
         posy_6_ff <= posy_5_ff;
         posz_6_ff <= posz_5_ff;
         for (int k = 0; k < 6; k++) begin
            phi_6_ff[k] <= 54'(mh_w) * 54'(f_5_ff[k]);
            plo_6_ff[k] <= 65'(ml_w) * 65'(f_5_ff[k]);
            qhi_6_ff[k] <= 37'(sh_w) * 37'(g_5_ff[k]);
            qlo_6_ff[k] <= 65'(sl_w) * 65'(g_5_ff[k]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         lo_sum_w[k] = 66'(plo_6_ff[k]) + 66'(qlo_6_ff[k]) + 66'sd536870912;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         posx_7_ff <= posx_6_ff;
         posy_7_ff <= posy_6_ff;
         posz_7_ff <= posz_6_ff;
         for (int k = 0; k < 6; k++) begin
            lo_7_ff[k] <= lo_sum_w[k][65:30];
            hi_7_ff[k] <= 55'(phi_6_ff[k]) + 55'(qhi_6_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         posx_8_ff <= posx_7_ff;
         posy_8_ff <= posy_7_ff;
         posz_8_ff <= posz_7_ff;
         for (int k = 0; k < 6; k++) begin
            cov_8_ff[k] <= sat_cov(66'(hi_7_ff[k]) + 66'(lo_7_ff[k]));
         end
      end
   end

   assign pos_x  = posx_8_ff;
   assign pos_y  = posy_8_ff;
   assign pos_z  = posz_8_ff;
   assign cov_xx = cov_8_ff[0];
   assign cov_xy = cov_8_ff[1];
   assign cov_xz = cov_8_ff[2];
   assign cov_yy = cov_8_ff[3];
   assign cov_yz = cov_8_ff[4];
   assign cov_zz = cov_8_ff[5];

endmodule

// File: rtl/radar_spherical_to_cartesian_cov_top.sv
// Throughput: one beat per cycle while rsp_ready is high; the two CORDIC pipelines and the
// eight-stage multiplier tree each take a new beat every cycle, and a stalled response only
// blocks full stages.
// Reset: synchronous, active high; clears all stage valid bits and the three sigma registers.
// Depends on rsc_pkg, rsc_pipe_ctrl, rsc_cordic and rsc_cov.
module radar_spherical_to_cartesian_cov_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_azimuth,
   input  logic [15:0]         req_zenith,
   input  logic [23:0]         req_slant_range,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsc_pkg::pos_type    rsp_pos_x,
   output rsc_pkg::pos_type    rsp_pos_y,
   output rsc_pkg::pos_type    rsp_pos_z,
   output rsc_pkg::cov_type    rsp_cov_xx,
   output rsc_pkg::cov_type    rsp_cov_xy,
   output rsc_pkg::cov_type    rsp_cov_xz,
   output rsc_pkg::cov_type    rsp_cov_yy,
   output rsc_pkg::cov_type    rsp_cov_yz,
   output rsc_pkg::cov_type    rsp_cov_zz,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import rsc_pkg::*;

   localparam int TRIG_DEPTH = CORDIC_STAGES + 2;
   localparam int DEPTH      = TRIG_DEPTH + MATH_STAGES;

   logic [DEPTH-1:0] stage_en;
   logic [15:0] az_sigma_ff, ze_sigma_ff, rg_sigma_ff;
   logic [23:0] range_ff [0:TRIG_DEPTH-1];
   q30_type sin_az, cos_az, sin_ze, cos_ze;

   always_ff @(posedge clock) begin
      if (reset) begin
         az_sigma_ff <= '0;
         ze_sigma_ff <= '0;
         rg_sigma_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AZIMUTH_SIGMA: az_sigma_ff <= csr_wdata;
            CSR_ZENITH_SIGMA:  ze_sigma_ff <= csr_wdata;
            CSR_RANGE_SIGMA:   rg_sigma_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rsc_pipe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .stage_en  (stage_en)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         range_ff[0] <= req_slant_range;
      end
      for (int k = 1; k < TRIG_DEPTH; k++) begin
         if (stage_en[k]) begin
            range_ff[k] <= range_ff[k-1];
         end
      end
   end

   rsc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
      .clock    (clock),
      .stage_en (stage_en[TRIG_DEPTH-1:0]),
      .angle    (req_azimuth),
      .sin_out  (sin_az),
      .cos_out  (cos_az)
   );

   rsc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ze (
      .clock    (clock),
      .stage_en (stage_en[TRIG_DEPTH-1:0]),
      .angle    (req_zenith),
      .sin_out  (sin_ze),
      .cos_out  (cos_ze)
   );

   rsc_cov u_cov (
      .clock         (clock),
      .stage_en      (stage_en[DEPTH-1:TRIG_DEPTH]),
      .slant_range   (range_ff[TRIG_DEPTH-1]),
      .sin_az        (sin_az),
      .cos_az        (cos_az),
      .sin_ze        (sin_ze),
      .cos_ze        (cos_ze),
      .azimuth_sigma (az_sigma_ff),
      .zenith_sigma  (ze_sigma_ff),
      .range_sigma   (rg_sigma_ff),
      .pos_x         (rsp_pos_x),
      .pos_y         (rsp_pos_y),
      .pos_z         (rsp_pos_z),
      .cov_xx        (rsp_cov_xx),
      .cov_xy        (rsp_cov_xy),
      .cov_xz        (rsp_cov_xz),
      .cov_yy        (rsp_cov_yy),
      .cov_yz        (rsp_cov_yz),
      .cov_zz        (rsp_cov_zz)
   );

endmodule
